// ===== rtl/lmsc_pkg.sv =====
// lmsc_pkg: shared widths, reset values, command and register codes and the
// item and configuration structs of the led matrix scan and crossfade block
// no dependencies
`default_nettype none

package lmsc_pkg;

  // default matrix size
  localparam int DEF_COLUMNS = 32;
  localparam int DEF_ROWS    = 16;

  // field widths
  localparam int CMD_W      = 2;
  localparam int PX_W       = 5;
  localparam int PY_W       = 4;
  localparam int TICKS_W    = 24;
  localparam int ROW_W      = 4;
  localparam int BITS_W     = 32;
  localparam int SCAN_W     = 5;
  localparam int START_W    = 4;
  localparam int NROWS_W    = 5;
  localparam int PERIOD_W   = 8;
  localparam int SHOWN_W    = 8;
  localparam int PROD_W     = SHOWN_W + TICKS_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [START_W-1:0]  START_ROW_RST  = 4'd0;
  localparam logic [NROWS_W-1:0]  NUM_ROWS_RST   = 5'd16;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 8'd14;
  localparam logic [SCAN_W-1:0]   SCAN_ROW_RST   =
    SCAN_W'({1'b0, START_ROW_RST} + NUM_ROWS_RST);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SWAP  = 2'd2,
    CMD_FADE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ROW  = 2'd0,
    CFG_NUM_ROWS   = 2'd1,
    CFG_PWM_PERIOD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    cmd_t                command;
    logic [PX_W-1:0]     pixel_x;
    logic [PY_W-1:0]     pixel_y;
    logic                pixel_value;
    logic [TICKS_W-1:0]  transition_ticks;
  } item_t;

  typedef struct packed {
    logic [START_W-1:0]  start_row;
    logic [NROWS_W-1:0]  num_rows;
    logic [PERIOD_W-1:0] pwm_period;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/led_matrix_scan_crossfade.sv =====
// led_matrix_scan_crossfade: row-scanned led matrix driver, two frame buffers, crossfade
// path: a scan tick passes the front register, the queue and the result register to the out_ ports
// throughput: one item per cycle while no stall holds it, set by the execute stage in lmsc_back
// reset: synchronous, active low; clears control state and both buffers
// depends on lmsc_pkg, lmsc_front, lmsc_queue, lmsc_back
`default_nettype none

module led_matrix_scan_crossfade #(
  parameter int COLUMNS = lmsc_pkg::DEF_COLUMNS,
  parameter int ROWS    = lmsc_pkg::DEF_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [lmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // item channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [lmsc_pkg::CMD_W-1:0]      in_command,
  input  wire logic [lmsc_pkg::PX_W-1:0]       in_pixel_x,
  input  wire logic [lmsc_pkg::PY_W-1:0]       in_pixel_y,
  input  wire logic                           in_pixel_value,
  input  wire logic [lmsc_pkg::TICKS_W-1:0]    in_transition_ticks,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [lmsc_pkg::ROW_W-1:0]           out_row_index,
  output logic [lmsc_pkg::BITS_W-1:0]          out_row_bits,
  output logic                                out_first_row,
  output logic                                out_fading
);

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  logic [lmsc_pkg::START_W-1:0]  start_row_r, start_row_nxt;
  logic [lmsc_pkg::NROWS_W-1:0]  num_rows_r, num_rows_nxt;
  logic [lmsc_pkg::PERIOD_W-1:0] pwm_period_r, pwm_period_nxt;
  lmsc_pkg::cfg_t                cfg;

  // front to queue transfer
  logic            push_valid;
  logic            push_ready;
  lmsc_pkg::item_t push_item;

  // queue to back transfer
  logic            q_valid;
  logic            q_pop;
  lmsc_pkg::item_t q_head;

  always_comb begin
    start_row_nxt  = start_row_r;
    num_rows_nxt   = num_rows_r;
    pwm_period_nxt = pwm_period_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lmsc_pkg::CFG_START_ROW:  start_row_nxt  = cfg_wdata[lmsc_pkg::START_W-1:0];
        lmsc_pkg::CFG_NUM_ROWS:   num_rows_nxt   = cfg_wdata[lmsc_pkg::NROWS_W-1:0];
        lmsc_pkg::CFG_PWM_PERIOD: pwm_period_nxt = cfg_wdata[lmsc_pkg::PERIOD_W-1:0];
        default:                  start_row_nxt  = start_row_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_row_r  <= lmsc_pkg::START_ROW_RST;
      num_rows_r   <= lmsc_pkg::NUM_ROWS_RST;
      pwm_period_r <= lmsc_pkg::PWM_PERIOD_RST;
    end else begin
      start_row_r  <= start_row_nxt;
      num_rows_r   <= num_rows_nxt;
      pwm_period_r <= pwm_period_nxt;
    end
  end

  assign cfg.start_row  = start_row_r;
  assign cfg.num_rows   = num_rows_r;
  assign cfg.pwm_period = pwm_period_r;

  // front: takes a transfer each cycle unless in_stall is high, and decodes the command
  lmsc_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .in_pixel_value      (in_pixel_value),
    .in_transition_ticks (in_transition_ticks),
    .push_valid          (push_valid),
    .push_ready          (push_ready),
    .push_item           (push_item)
  );

  // short queue so a held result stalls only scan ticks in the back
  lmsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_head)
  );

  // back: buffers, scan, crossfade and the result register
  lmsc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .head_valid    (q_valid),
    .head          (q_head),
    .head_pop      (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_row_bits  (out_row_bits),
    .out_first_row (out_first_row),
    .out_fading    (out_fading)
  );

`ifndef SYNTHESIS
  // no result held straight after reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result only appears after a scan tick left the queue
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop && q_head.command == lmsc_pkg::CMD_TICK))
    else $error("result without a scan tick");

  // with the result register empty the back always drains the queue
  a_back_no_hang: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !out_valid |-> q_pop)
    else $error("back stalled with free result register");
`endif

endmodule

`default_nettype wire

// ===== rtl/lmsc_front.sv =====
// lmsc_front: input register that takes items and classifies the command
// depends on lmsc_pkg
`default_nettype none

module lmsc_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lmsc_pkg::CMD_W-1:0]   in_command,
  input  wire logic [lmsc_pkg::PX_W-1:0]    in_pixel_x,
  input  wire logic [lmsc_pkg::PY_W-1:0]    in_pixel_y,
  input  wire logic                        in_pixel_value,
  input  wire logic [lmsc_pkg::TICKS_W-1:0] in_transition_ticks,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output lmsc_pkg::item_t                  push_item
);

  logic            fr_valid_r;
  logic            fr_valid_nxt;
  lmsc_pkg::item_t fr_item_r;
  lmsc_pkg::item_t fr_item_nxt;
  lmsc_pkg::cmd_t  cmd_dec;
  logic            accept;

  assign in_stall   = fr_valid_r & ~push_ready;
  assign accept     = in_valid & ~in_stall;
  assign push_valid = fr_valid_r;
  assign push_item  = fr_item_r;

  always_comb begin
    unique case (in_command)
      lmsc_pkg::CMD_TICK:  cmd_dec = lmsc_pkg::CMD_TICK;
      lmsc_pkg::CMD_WRITE: cmd_dec = lmsc_pkg::CMD_WRITE;
      lmsc_pkg::CMD_SWAP:  cmd_dec = lmsc_pkg::CMD_SWAP;
      default:             cmd_dec = lmsc_pkg::CMD_FADE;
    endcase
  end

  always_comb begin
    fr_valid_nxt = accept | (fr_valid_r & ~push_ready);
    fr_item_nxt  = fr_item_r;
    if (accept) begin
      fr_item_nxt.command          = cmd_dec;
      fr_item_nxt.pixel_x          = in_pixel_x;
      fr_item_nxt.pixel_y          = in_pixel_y;
      fr_item_nxt.pixel_value      = in_pixel_value;
      fr_item_nxt.transition_ticks = in_transition_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/lmsc_queue.sv =====
// lmsc_queue: short fifo of classified items between front and back
// depends on lmsc_pkg
`default_nettype none

module lmsc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire lmsc_pkg::item_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop,
  output lmsc_pkg::item_t      pop_item
);

  localparam int QA = (lmsc_pkg::QUEUE_DEPTH > 1) ? $clog2(lmsc_pkg::QUEUE_DEPTH) : 1;
  localparam logic [QA:0] FULL = (QA + 1)'(lmsc_pkg::QUEUE_DEPTH);
  localparam logic [QA-1:0] LAST = QA'(lmsc_pkg::QUEUE_DEPTH - 1);

  lmsc_pkg::item_t entry_r [lmsc_pkg::QUEUE_DEPTH];
  logic [QA-1:0]   wr_ptr_r;
  logic [QA-1:0]   wr_ptr_nxt;
  logic [QA-1:0]   rd_ptr_r;
  logic [QA-1:0]   rd_ptr_nxt;
  logic [QA:0]     count_r;
  logic [QA:0]     count_nxt;
  logic            do_push;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid & push_ready;
  assign pop_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lmsc_back.sv =====
// lmsc_back: executes items against the two frame buffers, the scan and the
// crossfade counters, and holds the result register
// depends on lmsc_pkg
`default_nettype none

module lmsc_back #(
  parameter int COLUMNS = lmsc_pkg::DEF_COLUMNS,
  parameter int ROWS    = lmsc_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lmsc_pkg::cfg_t              cfg,
  input  wire logic                        head_valid,
  input  wire lmsc_pkg::item_t             head,
  output logic                             head_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lmsc_pkg::ROW_W-1:0]        out_row_index,
  output logic [lmsc_pkg::BITS_W-1:0]       out_row_bits,
  output logic                             out_first_row,
  output logic                             out_fading
);

  localparam int EXT_W = (COLUMNS > lmsc_pkg::BITS_W) ? COLUMNS : lmsc_pkg::BITS_W;
  localparam logic [lmsc_pkg::SCAN_W:0] ROWS_LIM = (lmsc_pkg::SCAN_W + 1)'(ROWS);

  // frame buffers, bit writable, cleared as a whole
  logic [COLUMNS-1:0] buf_a_r [ROWS];
  logic [COLUMNS-1:0] buf_b_r [ROWS];

  logic                            front_is_b_r, front_is_b_nxt;
  logic [lmsc_pkg::SCAN_W-1:0]     scan_row_r, scan_row_nxt;
  logic                            fade_on_r, fade_on_nxt;
  logic                            show_back_r, show_back_nxt;
  logic [lmsc_pkg::PERIOD_W-1:0]   pwm_pos_r, pwm_pos_nxt;
  logic [lmsc_pkg::TICKS_W-1:0]    frame_cnt_r, frame_cnt_nxt;
  logic [lmsc_pkg::TICKS_W-1:0]    latched_r, latched_nxt;
  logic [lmsc_pkg::SHOWN_W-1:0]    shown_r, shown_nxt;
  logic [lmsc_pkg::TICKS_W-1:0]    fade_len_r, fade_len_nxt;
  // running products shown * fade_len and pwm_pos * latched
  logic [lmsc_pkg::PROD_W-1:0]     prod_shown_r, prod_shown_nxt;
  logic [lmsc_pkg::PROD_W-1:0]     prod_pos_r, prod_pos_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [lmsc_pkg::ROW_W-1:0]      out_index_r, out_index_nxt;
  logic [lmsc_pkg::BITS_W-1:0]     out_bits_r, out_bits_nxt;
  logic                            out_first_r, out_first_nxt;
  logic                            out_fading_r, out_fading_nxt;

  logic                            out_free;
  logic                            clr_a, clr_b, wr_a, wr_b;
  logic [lmsc_pkg::SCAN_W:0]       window_sum, window_end, scan_inc;
  logic                            scan_wrap;
  logic [lmsc_pkg::SCAN_W-1:0]     scan_next;
  logic [lmsc_pkg::TICKS_W-1:0]    fc_inc;
  logic [lmsc_pkg::PERIOD_W:0]     pos_inc;
  logic                            pwm_latch;
  logic [lmsc_pkg::PROD_W-1:0]     prod_pos_inc;
  logic                            pick_back;
  logic                            frame_step;
  logic                            show_upd;
  logic [lmsc_pkg::TICKS_W-1:0]    latched_cur;
  logic                            fade_done;
  logic                            use_back;
  logic [COLUMNS-1:0]              row_a, row_b, row_show;
  logic [EXT_W-1:0]                row_ext;

  assign out_free = ~out_valid_r | ~out_stall;
  assign head_pop = head_valid & ((head.command != lmsc_pkg::CMD_TICK) | out_free);

  assign out_valid     = out_valid_r;
  assign out_row_index = out_index_r;
  assign out_row_bits  = out_bits_r;
  assign out_first_row = out_first_r;
  assign out_fading    = out_fading_r;

  // scan window and frame pwm arithmetic
  assign window_sum = {2'b00, cfg.start_row} + {1'b0, cfg.num_rows};
  assign window_end = (window_sum > ROWS_LIM) ? ROWS_LIM : window_sum;
  assign scan_inc   = {1'b0, scan_row_r} + 1'b1;
  assign scan_wrap  = (scan_inc >= window_end);
  assign scan_next  = scan_wrap ? {1'b0, cfg.start_row} : scan_inc[lmsc_pkg::SCAN_W-1:0];

  assign fc_inc       = (frame_cnt_r != '1) ? frame_cnt_r + 1'b1 : frame_cnt_r;
  assign pos_inc      = {1'b0, pwm_pos_r} + 1'b1;
  assign pwm_latch    = (pos_inc[lmsc_pkg::PERIOD_W-1:0] >= cfg.pwm_period);
  assign prod_pos_inc = pos_inc[lmsc_pkg::PERIOD_W] ? '0
                      : prod_pos_r + {{lmsc_pkg::SHOWN_W{1'b0}}, latched_r};
  assign pick_back    = ~pwm_latch & (prod_shown_r < prod_pos_inc);
  assign frame_step   = scan_wrap & fade_on_r;
  assign show_upd     = frame_step ? pick_back : show_back_r;
  assign latched_cur  = (frame_step && pwm_latch) ? fc_inc : latched_r;
  assign fade_done    = fade_on_r & (latched_cur >= fade_len_r);
  assign use_back     = fade_on_r & show_upd;

  // row fetch from both buffers at the next scan row
  always_comb begin
    row_a = '0;
    row_b = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (32'(scan_next) == 32'(r)) begin
        row_a = buf_a_r[r];
        row_b = buf_b_r[r];
      end
    end
  end

  // back buffer is b when front is a
  assign row_show = (use_back ^ front_is_b_r) ? row_b : row_a;
  assign row_ext  = EXT_W'(row_show);

  always_comb begin
    front_is_b_nxt = front_is_b_r;
    scan_row_nxt   = scan_row_r;
    fade_on_nxt    = fade_on_r;
    show_back_nxt  = show_back_r;
    pwm_pos_nxt    = pwm_pos_r;
    frame_cnt_nxt  = frame_cnt_r;
    latched_nxt    = latched_r;
    shown_nxt      = shown_r;
    fade_len_nxt   = fade_len_r;
    prod_shown_nxt = prod_shown_r;
    prod_pos_nxt   = prod_pos_r;
    out_index_nxt  = out_index_r;
    out_bits_nxt   = out_bits_r;
    out_first_nxt  = out_first_r;
    out_fading_nxt = out_fading_r;
    out_valid_nxt  = out_valid_r & out_stall;
    clr_a = 1'b0;
    clr_b = 1'b0;
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    if (head_pop) begin
      unique case (head.command)
        lmsc_pkg::CMD_TICK: begin
          scan_row_nxt  = scan_next;
          show_back_nxt = show_upd;
          if (frame_step) begin
            frame_cnt_nxt = fc_inc;
            if (pwm_latch) begin
              pwm_pos_nxt    = '0;
              latched_nxt    = fc_inc;
              shown_nxt      = '0;
              prod_shown_nxt = '0;
              prod_pos_nxt   = '0;
            end else begin
              pwm_pos_nxt  = pos_inc[lmsc_pkg::PERIOD_W-1:0];
              prod_pos_nxt = prod_pos_inc;
              if (pick_back && shown_r != '1) begin
                shown_nxt      = shown_r + 1'b1;
                prod_shown_nxt = prod_shown_r + {{lmsc_pkg::SHOWN_W{1'b0}}, fade_len_r};
              end
            end
          end
          out_valid_nxt  = 1'b1;
          out_index_nxt  = scan_next[lmsc_pkg::ROW_W-1:0];
          out_bits_nxt   = row_ext[lmsc_pkg::BITS_W-1:0];
          out_first_nxt  = (scan_next == {1'b0, cfg.start_row});
          out_fading_nxt = fade_on_r;
          // fade finished: swap and clear the old front
          if (fade_done) begin
            fade_on_nxt    = 1'b0;
            front_is_b_nxt = ~front_is_b_r;
            show_back_nxt  = 1'b1;
            clr_a          = ~front_is_b_r;
            clr_b          = front_is_b_r;
          end
        end
        lmsc_pkg::CMD_WRITE: begin
          wr_a = front_is_b_r;
          wr_b = ~front_is_b_r;
        end
        lmsc_pkg::CMD_SWAP: begin
          front_is_b_nxt = ~front_is_b_r;
          show_back_nxt  = 1'b1;
          clr_a          = ~front_is_b_r;
          clr_b          = front_is_b_r;
        end
        lmsc_pkg::CMD_FADE: begin
          pwm_pos_nxt    = '0;
          frame_cnt_nxt  = '0;
          latched_nxt    = '0;
          shown_nxt      = '0;
          prod_shown_nxt = '0;
          prod_pos_nxt   = '0;
          fade_len_nxt   = head.transition_ticks;
          fade_on_nxt    = 1'b1;
        end
        default: begin
          fade_on_nxt = fade_on_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_is_b_r <= 1'b0;
      scan_row_r   <= lmsc_pkg::SCAN_ROW_RST;
      fade_on_r    <= 1'b0;
      show_back_r  <= 1'b0;
      pwm_pos_r    <= '0;
      frame_cnt_r  <= '0;
      latched_r    <= '0;
      shown_r      <= '0;
      fade_len_r   <= '0;
      prod_shown_r <= '0;
      prod_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      front_is_b_r <= front_is_b_nxt;
      scan_row_r   <= scan_row_nxt;
      fade_on_r    <= fade_on_nxt;
      show_back_r  <= show_back_nxt;
      pwm_pos_r    <= pwm_pos_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      latched_r    <= latched_nxt;
      shown_r      <= shown_nxt;
      fade_len_r   <= fade_len_nxt;
      prod_shown_r <= prod_shown_nxt;
      prod_pos_r   <= prod_pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r  <= out_index_nxt;
    out_bits_r   <= out_bits_nxt;
    out_first_r  <= out_first_nxt;
    out_fading_r <= out_fading_nxt;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        if (!rst_n || clr_a) begin
          buf_a_r[r][c] <= 1'b0;
        end else if (wr_a && 32'(head.pixel_y) == 32'(r) && 32'(head.pixel_x) == 32'(c)) begin
          buf_a_r[r][c] <= head.pixel_value;
        end
        if (!rst_n || clr_b) begin
          buf_b_r[r][c] <= 1'b0;
        end else if (wr_b && 32'(head.pixel_y) == 32'(r) && 32'(head.pixel_x) == 32'(c)) begin
          buf_b_r[r][c] <= head.pixel_value;
        end
      end
    end
  end

endmodule

`default_nettype wire
